// ===== rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the sync-framed byte deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_SYNC_FIRST  = 2'd0,
      REG_SYNC_SECOND = 2'd1,
      REG_ACK_COMMAND = 2'd2
   } reg_index_type;

   localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
   localparam logic [7:0] ACK_COMMAND_RST = 8'h00;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_CMD  = 3'd1,
      PH_LEN  = 3'd2,
      PH_PAY  = 3'd3,
      PH_CHK  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD     = 2'd2,
      KIND_ABANDON = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [7:0] ack_command;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] command;
      logic [7:0] length;
      logic [7:0] payload_byte;
      logic [7:0] byte_index;
      logic       send_ack;
      logic       peer_ack;
   } rsp_type;

endpackage

// ===== rtl/sfd_if.sv =====
// ----------------------------------------------------------------------------
// sfd_if
// Valid/ready channel interfaces for received bytes and deframer results.
// ----------------------------------------------------------------------------
interface sfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] command;
   logic [7:0] length;
   logic [7:0] payload_byte;
   logic [7:0] byte_index;
   logic       send_ack;
   logic       peer_ack;

   modport source (output valid, output kind, output command, output length,
                   output payload_byte, output byte_index, output send_ack,
                   output peer_ack, input ready);
   modport sink   (input valid, input kind, input command, input length,
                   input payload_byte, input byte_index, input send_ack,
                   input peer_ack, output ready);
endinterface

// ===== rtl/sfd_csr.sv =====
// ----------------------------------------------------------------------------
// sfd_csr
// APB register file: sync byte values and acknowledge command code.
// ----------------------------------------------------------------------------
module sfd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sfd_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sfd_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output sfd_pkg::cfg_type                  cfg
);
   import sfd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign reg_sel = reg_index_type'(paddr[3:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_SYNC_FIRST:  cfg_in.sync_first  = pwdata[7:0];
            REG_SYNC_SECOND: cfg_in.sync_second = pwdata[7:0];
            REG_ACK_COMMAND: cfg_in.ack_command = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_SYNC_FIRST:  prdata = {24'd0, cfg_ff.sync_first};
         REG_SYNC_SECOND: prdata = {24'd0, cfg_ff.sync_second};
         REG_ACK_COMMAND: prdata = {24'd0, cfg_ff.ack_command};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= SYNC_FIRST_RST;
         cfg_ff.sync_second <= SYNC_SECOND_RST;
         cfg_ff.ack_command <= ACK_COMMAND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/sfd_parser.sv =====
// ----------------------------------------------------------------------------
// sfd_parser
// Frame state machine, running checksum and result formation per byte.
// ----------------------------------------------------------------------------
module sfd_parser (
   input  logic             clock,
   input  logic             reset,
   input  sfd_pkg::cfg_type cfg,
   input  logic             accept,
   input  logic [7:0]       rx_byte,
   output logic             res_valid,
   output sfd_pkg::rsp_type res
);
   import sfd_pkg::*;

   phase_type  phase_ff,   phase_in;
   logic [7:0] prev_ff,    prev_in;
   logic [7:0] cmd_ff,     cmd_in;
   logic [7:0] len_ff,     len_in;
   logic [7:0] count_ff,   count_in;
   logic [7:0] sum_ff,     sum_in;
   logic       sync_hit;
   logic [7:0] count_inc;
   logic [7:0] sum_add;

   assign sync_hit  = (prev_ff == cfg.sync_first) && (rx_byte == cfg.sync_second);
   assign count_inc = count_ff + 8'd1;
   assign sum_add   = sum_ff + rx_byte;

   // next state
   always_comb begin
      phase_in = phase_ff;
      prev_in  = prev_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      if (accept) begin
         prev_in = rx_byte;
         if (sync_hit) begin
            phase_in = PH_CMD;
         end else begin
            case (phase_ff)
               PH_CMD: begin
                  cmd_in   = rx_byte;
                  sum_in   = rx_byte;
                  phase_in = PH_LEN;
               end
               PH_LEN: begin
                  len_in   = rx_byte;
                  sum_in   = sum_add;
                  count_in = '0;
                  phase_in = (rx_byte != 8'd0) ? PH_PAY : PH_CHK;
               end
               PH_PAY: begin
                  sum_in   = sum_add;
                  count_in = count_inc;
                  if (count_inc >= len_ff) begin
                     phase_in = PH_CHK;
                  end
               end
               PH_CHK:  phase_in = PH_HUNT;
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   // outputs
   always_comb begin
      res_valid        = 1'b0;
      res.kind         = KIND_PAYLOAD;
      res.command      = cmd_ff;
      res.length       = len_ff;
      res.payload_byte = '0;
      res.byte_index   = '0;
      res.send_ack     = 1'b0;
      res.peer_ack     = 1'b0;
      if (accept) begin
         if (sync_hit) begin
            if (phase_ff == PH_PAY || phase_ff == PH_CHK) begin
               res_valid = 1'b1;
               res.kind  = KIND_ABANDON;
            end
         end else begin
            case (phase_ff)
               PH_PAY: begin
                  res_valid        = 1'b1;
                  res.payload_byte = rx_byte;
                  res.byte_index   = count_ff;
               end
               PH_CHK: begin
                  res_valid = 1'b1;
                  if (rx_byte == sum_ff) begin
                     res.kind     = KIND_GOOD;
                     res.send_ack = 1'b1;
                     res.peer_ack = (cmd_ff == cfg.ack_command);
                  end else begin
                     res.kind = KIND_BAD;
                  end
               end
               default: res_valid = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         prev_ff  <= '0;
         cmd_ff   <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   a_prev_tracks: assert property (@(posedge clock) disable iff (reset)
      accept |=> prev_ff == $past(rx_byte))
      else $error("previous byte not captured");

   a_payload_phase: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_PAYLOAD |-> phase_ff == PH_PAY && !sync_hit)
      else $error("payload transaction outside payload phase");

   a_verdict_hunts: assert property (@(posedge clock) disable iff (reset)
      accept && !sync_hit && phase_ff == PH_CHK |=> phase_ff == PH_HUNT)
      else $error("no return to hunting after verdict");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAY |-> count_ff < len_ff)
      else $error("payload count past frame length");

endmodule

// ===== rtl/sfd_outbuf.sv =====
// ----------------------------------------------------------------------------
// sfd_outbuf
// Result register with skid stage; decouples input ready from result stall.
// ----------------------------------------------------------------------------
module sfd_outbuf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfd_pkg::rsp_type push_data,
   output logic             can_accept,
   output logic             out_valid,
   output sfd_pkg::rsp_type out_data,
   input  logic             out_ready
);
   import sfd_pkg::*;

   logic    head_valid_ff, head_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type head_ff,       head_in;
   rsp_type skid_ff,       skid_in;
   logic    head_free;

   assign head_free  = !head_valid_ff || out_ready;
   assign can_accept = !skid_valid_ff;
   assign out_valid  = head_valid_ff;
   assign out_data   = head_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (head_free) begin
         if (skid_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = push;
            head_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid holds data with empty head");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("transaction pushed into full buffer");

   a_empty_head_no_skid: assert property (@(posedge clock) disable iff (reset)
      !head_valid_ff |=> !skid_valid_ff)
      else $error("skid filled while head empty");

endmodule

// ===== rtl/sync_framed_byte_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_framed_byte_deframer
// Recognizes sync-framed packets with additive checksum in a byte stream.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle if the skid entry is empty; frame state and
// running sum update per byte. Results are registered in the buffer head.
// A two-entry result buffer keeps req ready while one result is stalled.
// Reset: synchronous; phase to hunting, byte/sum registers to zero, sync
// registers to 0xAA/0x55 and acknowledge command to 0x00.
module sync_framed_byte_deframer (
   input  logic                           clock,
   input  logic                           reset,
   sfd_req_if.sink                        req_chan,
   sfd_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sfd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sfd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sfd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import sfd_pkg::*;

   cfg_type cfg;
   logic    accept;
   logic    can_accept;
   logic    res_valid;
   rsp_type res;
   rsp_type out_data;

   assign req_chan.ready = can_accept;
   assign accept         = req_chan.valid & can_accept;

   sfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .rx_byte   (req_chan.rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   sfd_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .can_accept (can_accept),
      .out_valid  (rsp_chan.valid),
      .out_data   (out_data),
      .out_ready  (rsp_chan.ready)
   );

   assign rsp_chan.kind         = out_data.kind;
   assign rsp_chan.command      = out_data.command;
   assign rsp_chan.length       = out_data.length;
   assign rsp_chan.payload_byte = out_data.payload_byte;
   assign rsp_chan.byte_index   = out_data.byte_index;
   assign rsp_chan.send_ack     = out_data.send_ack;
   assign rsp_chan.peer_ack     = out_data.peer_ack;

endmodule
